### rtl/iafp_pkg.sv
package iafp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned RawW     = 16;
  localparam int unsigned AngleW   = 22;
  localparam int unsigned CntW     = 4;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CntW-1:0] LastCnt = CntW'(10);

  localparam logic [CfgIdxW-1:0] CfgHeader = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgType   = CfgIdxW'(1);

  localparam logic [ByteW-1:0] HeaderReset = 8'h55;
  localparam logic [ByteW-1:0] TypeReset   = 8'h55;

  typedef struct packed {
    logic fire;
    logic ok;
  } step_t;

  typedef struct packed {
    logic [RawW-1:0] roll;
    logic [RawW-1:0] pitch;
    logic [RawW-1:0] yaw;
  } held_t;

  // raw * 45 = raw * (32 + 8 + 4 + 1), degrees in Q13
  function automatic logic signed [AngleW-1:0] scale_angle(input logic [RawW-1:0] raw);
    logic signed [AngleW-1:0] v;
    v = AngleW'($signed(raw));
    return (v <<< 5) + (v <<< 3) + (v <<< 2) + v;
  endfunction

endpackage

### rtl/imu_angle_frame_parser.sv
// Channel | Direction | Handshake         | Payload
// cfg     | in        | cfg_valid/ready   | cfg_index_i, cfg_data_i
// in      | in        | in_valid/stall    | rx_byte_i
// out     | out       | out_valid/stall   | checksum_ok_o, roll/pitch/yaw_angle_o
//
// One byte per cycle while in_stall_o is low: input register, then parse step into the result register.
// A byte leaves the input register the cycle after its transfer, unless it completes
// a frame while a result waits; a frame's result loads at the edge its checksum byte leaves.
// in_stall_o rises only while a result waits and the next byte completes a frame.
// Reset: hunting, held angles zero, header and type 0x55; cfg is always ready.
module imu_angle_frame_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [iafp_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [iafp_pkg::ByteW-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [iafp_pkg::ByteW-1:0]          rx_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                checksum_ok_o,
  output logic signed [iafp_pkg::AngleW-1:0]  roll_angle_o,
  output logic signed [iafp_pkg::AngleW-1:0]  pitch_angle_o,
  output logic signed [iafp_pkg::AngleW-1:0]  yaw_angle_o
);

  logic [iafp_pkg::ByteW-1:0] header_q, type_q;
  logic                       in_vld_q;
  logic [iafp_pkg::ByteW-1:0] in_byte_q;
  logic                       out_vld_q;
  logic                       out_free;
  logic                       advance;
  logic                       in_xfer;
  iafp_pkg::step_t            step;
  iafp_pkg::held_t            held_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= iafp_pkg::HeaderReset;
      type_q   <= iafp_pkg::TypeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        iafp_pkg::CfgHeader: header_q <= cfg_data_i;
        iafp_pkg::CfgType:   type_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && (!step.fire || out_free);
  assign in_stall_o = in_vld_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= rx_byte_i;
    end
  end

  iafp_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_en_i     (advance),
    .rx_byte_i     (in_byte_q),
    .header_byte_i (header_q),
    .frame_type_i  (type_q),
    .step_o        (step),
    .held_d_o      (held_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && step.fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step.fire) begin
      checksum_ok_o <= step.ok;
      roll_angle_o  <= iafp_pkg::scale_angle(held_d.roll);
      pitch_angle_o <= iafp_pkg::scale_angle(held_d.pitch);
      yaw_angle_o   <= iafp_pkg::scale_angle(held_d.yaw);
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

### rtl/iafp_parser.sv
module iafp_parser (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_en_i,
  input  logic [iafp_pkg::ByteW-1:0]       rx_byte_i,
  input  logic [iafp_pkg::ByteW-1:0]       header_byte_i,
  input  logic [iafp_pkg::ByteW-1:0]       frame_type_i,
  output iafp_pkg::step_t                  step_o,
  output iafp_pkg::held_t                  held_d_o
);

  logic [iafp_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [iafp_pkg::ByteW-1:0] sum_q, sum_d;
  logic [iafp_pkg::ByteW-1:0] data_q [4:9];
  iafp_pkg::held_t            held_q, held_d;

  always_comb begin
    step_o.fire = (cnt_q == iafp_pkg::LastCnt);
    step_o.ok   = (sum_q == rx_byte_i);
  end

  always_comb begin
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    held_d = held_q;
    if (cnt_q == '0) begin
      if (rx_byte_i == header_byte_i) begin
        cnt_d = iafp_pkg::CntW'(1);
        sum_d = rx_byte_i;
      end
    end else if (cnt_q == iafp_pkg::CntW'(1)) begin
      if (rx_byte_i == frame_type_i) begin
        cnt_d = iafp_pkg::CntW'(2);
        sum_d = sum_q + rx_byte_i;
      end else begin
        cnt_d = '0;
      end
    end else if (cnt_q == iafp_pkg::LastCnt) begin
      cnt_d = '0;
      if (step_o.ok) begin
        held_d.roll  = {data_q[5], data_q[4]};
        held_d.pitch = {data_q[7], data_q[6]};
        held_d.yaw   = {data_q[9], data_q[8]};
      end
    end else begin
      cnt_d = cnt_q + iafp_pkg::CntW'(1);
      sum_d = sum_q + rx_byte_i;
    end
  end

  assign held_d_o = held_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      held_q <= '0;
    end else if (step_en_i) begin
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      held_q <= held_d;
    end
  end

  for (genvar i = 4; i <= 9; i++) begin : g_data
    always_ff @(posedge clk_i) begin
      if (step_en_i && cnt_q == iafp_pkg::CntW'(i)) begin
        data_q[i] <= rx_byte_i;
      end
    end
  end

endmodule

### rtl/iafp_checker.sv
module iafp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic                                checksum_ok_o,
  input logic signed [iafp_pkg::AngleW-1:0]  roll_angle_o,
  input logic signed [iafp_pkg::AngleW-1:0]  pitch_angle_o,
  input logic signed [iafp_pkg::AngleW-1:0]  yaw_angle_o
);

  logic out_xfer;
  assign out_xfer = out_valid_o && !out_stall_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(roll_angle_o)
      && $stable(pitch_angle_o) && $stable(yaw_angle_o) && $stable(checksum_ok_o))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  a_bad_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !checksum_ok_o && $past(out_xfer) |->
      roll_angle_o == $past(roll_angle_o) && pitch_angle_o == $past(pitch_angle_o)
      && yaw_angle_o == $past(yaw_angle_o))
    else $error("bad frame changed held angles");

  a_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> roll_angle_o % 45 == 0 && pitch_angle_o % 45 == 0
      && yaw_angle_o % 45 == 0)
    else $error("angle not a multiple of the scale");

endmodule

bind imu_angle_frame_parser iafp_checker u_iafp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .checksum_ok_o (checksum_ok_o),
  .roll_angle_o  (roll_angle_o),
  .pitch_angle_o (pitch_angle_o),
  .yaw_angle_o   (yaw_angle_o)
);
